// ----- hw/rtl/pfbb_pkg.sv -----
package pfbb_pkg;

    // Default display geometry in pixels.
    localparam int DISPLAY_WIDTH_DEF  = 128;
    localparam int DISPLAY_HEIGHT_DEF = 64;

    // Item kinds. The fourth code is unused and is dropped on arrival.
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Operation requested from the frame store in one cycle.
    typedef struct packed {
        logic rmw;   // OR the mask into the addressed byte
        logic zero;  // write zero to the addressed byte
    } t_store_ctl;

endpackage

// ----- hw/rtl/page_framebuffer_bitmap_blit_core.sv -----
// Monochrome page-organized frame store with a transparent bitmap blit.
// The store holds DISPLAY_WIDTH columns by DISPLAY_HEIGHT rows in pages of
// eight rows; each byte covers eight vertical pixels of one column with the
// least significant bit at the top. A clear item zeroes the store, a draw item
// ORs one row-major bitmap byte (most significant bit leftmost) into the store
// at the position given by the internal row and byte column counters, with
// clipping at the display edges and at the bitmap width, and a read item
// returns one store byte on the output channel. A draw item walks its
// eight pixels one per cycle through the single read-modify-write port of the
// store; a draw byte whose row is past the bitmap height or off the display
// is taken without a pixel walk. A read passes through the read state and the
// output state, where it waits for the output register to empty. A clear
// writes one store byte per cycle through all DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT
// / 8) bytes (1024 at the default size). The same clearing pass runs after
// reset, and no input transfer is taken until it ends. Unused item kinds are
// taken and ignored.
module page_framebuffer_bitmap_blit_core #(
    parameter int DISPLAY_WIDTH  = pfbb_pkg::DISPLAY_WIDTH_DEF,
    parameter int DISPLAY_HEIGHT = pfbb_pkg::DISPLAY_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [10:0] i_origin_x,
    input  logic signed [10:0] i_origin_y,
    input  logic [7:0]         i_bitmap_width,
    input  logic [7:0]         i_bitmap_height,
    input  logic [7:0]         i_bitmap_byte,
    input  logic               i_last_byte,
    input  logic [2:0]         i_read_page,
    input  logic [6:0]         i_read_column,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_read_data
);

    localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_SIZE = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int AW         = $clog2(STORE_SIZE);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_DRAW  = 5'b00100,
        S_READ  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_out_valid;
    logic [7:0]           r_out_data;

    // Bitmap position of the next draw byte.
    logic [7:0]           r_row_cnt;
    logic [4:0]           r_col_cnt;

    // Working registers of the pixel walk.
    logic [7:0]           r_bits;
    logic signed [11:0]   r_x;
    logic [7:0]           r_i;
    logic [7:0]           r_w;
    logic [2:0]           r_k;
    logic [7:0]           r_mask;
    logic [AW-1:0]        r_base;

    // Read and clear addressing.
    logic [AW-1:0]        r_rd_addr;
    logic                 r_rd_ok;
    logic [AW-1:0]        r_clr_addr;

    logic                 w_accept;
    logic                 w_out_free;
    logic signed [11:0]   w_y;
    logic signed [11:0]   w_x0;
    logic                 w_row_ok;
    logic [5:0]           w_bytes_per_row;
    logic [5:0]           w_col_next;
    logic                 w_pix_ok;
    logic                 w_clr_last;
    logic                 w_rd_in_range;
    pfbb_pkg::t_store_ctl w_ctl;
    logic [AW-1:0]        w_addr;
    logic [7:0]           w_rd_data;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Display row of the current bitmap row and the display column of the
    // first pixel of the current byte.
    assign w_y  = 12'(i_origin_y) + $signed({4'b0000, r_row_cnt});
    assign w_x0 = 12'(i_origin_x) + $signed({4'b0000, r_col_cnt, 3'b000});
    assign w_row_ok = (r_row_cnt < i_bitmap_height) && !w_y[11]
                      && (w_y[10:0] < 11'(DISPLAY_HEIGHT));

    assign w_bytes_per_row = 6'(({1'b0, i_bitmap_width} + 9'd7) >> 3);
    assign w_col_next      = {1'b0, r_col_cnt} + 6'd1;

    // A pixel is written when it is set, lies inside the bitmap width and
    // lands on a display column.
    assign w_pix_ok = r_bits[7] && (r_i < r_w) && !r_x[11]
                      && (r_x[10:0] < 11'(DISPLAY_WIDTH));

    assign w_clr_last    = (r_clr_addr == AW'(STORE_SIZE - 1));
    assign w_rd_in_range = (int'(i_read_page) < PAGE_COUNT)
                           && (int'(i_read_column) < DISPLAY_WIDTH);

    always_comb begin
        w_ctl  = '0;
        w_addr = r_rd_addr;
        case (r_state)
            S_CLEAR: begin
                w_ctl.zero = 1'b1;
                w_addr     = r_clr_addr;
            end
            S_DRAW: begin
                w_ctl.rmw = w_pix_ok;
                w_addr    = r_base + AW'($unsigned(r_x));
            end
            default: begin
                w_addr = r_rd_addr;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_kind)
                        pfbb_pkg::KIND_CLEAR: n_state = S_CLEAR;
                        pfbb_pkg::KIND_DRAW:  n_state = w_row_ok ? S_DRAW : S_IDLE;
                        pfbb_pkg::KIND_READ:  n_state = S_READ;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_DRAW: begin
                if (r_k == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_row_cnt   <= '0;
            r_col_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end else begin
                r_clr_addr <= '0;
            end

            // The counters advance on every draw transfer, drawn or not.
            if (w_accept && (i_kind == pfbb_pkg::KIND_DRAW)) begin
                if (i_last_byte) begin
                    r_row_cnt <= '0;
                    r_col_cnt <= '0;
                end else if (w_col_next >= w_bytes_per_row) begin
                    r_row_cnt <= r_row_cnt + 8'd1;
                    r_col_cnt <= '0;
                end else begin
                    r_col_cnt <= 5'(w_col_next);
                end
            end

            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bits    <= i_bitmap_byte;
            r_x       <= w_x0;
            r_i       <= {r_col_cnt, 3'b000};
            r_w       <= i_bitmap_width;
            r_k       <= '0;
            r_mask    <= 8'b1 << w_y[2:0];
            r_base    <= AW'(int'(w_y[6:3]) * DISPLAY_WIDTH);
            r_rd_addr <= AW'(int'(i_read_page) * DISPLAY_WIDTH + int'(i_read_column));
            r_rd_ok   <= w_rd_in_range;
        end else if (r_state == S_DRAW) begin
            r_bits <= {r_bits[6:0], 1'b0};
            r_x    <= r_x + 12'sd1;
            r_i    <= r_i + 8'd1;
            r_k    <= r_k + 3'd1;
        end

        if ((r_state == S_OUT) && w_out_free) begin
            r_out_data <= r_rd_ok ? w_rd_data : 8'h00;
        end
    end

    pfbb_store #(
        .DEPTH (STORE_SIZE),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_addr    (w_addr),
        .i_mask    (r_mask),
        .o_rd_data (w_rd_data)
    );

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

// ----- hw/rtl/pfbb_store.sv -----
module pfbb_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pfbb_pkg::t_store_ctl i_ctl,
    input  logic [AW-1:0]        i_addr,
    input  logic [7:0]           i_mask,
    output logic [7:0]           o_rd_data
);

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_rmw;
    logic [AW-1:0] r_wr_addr;
    logic [7:0]    r_mask;

    // The read for a read-modify-write happens in the request cycle; the
    // merged byte is written back in the cycle after, from the registered
    // read data.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_addr];
        if (r_rmw) begin
            r_mem[r_wr_addr] <= r_rd_data | r_mask;
        end else if (i_ctl.zero) begin
            r_mem[i_addr] <= 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmw <= 1'b0;
        end else begin
            r_rmw <= i_ctl.rmw;
        end
        r_wr_addr <= i_addr;
        r_mask    <= i_mask;
    end

    assign o_rd_data = r_rd_data;

endmodule
